### sv/planar_chain_forward_kinematics_defines.svh
// Assertion macros for the planar chain forward kinematics block.
// Used by the port checker; depends on nothing else.
`ifndef PLANAR_CHAIN_FORWARD_KINEMATICS_DEFINES_SVH
`define PLANAR_CHAIN_FORWARD_KINEMATICS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCFK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCFK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pcfk_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// planar chain forward kinematics block. Depends on nothing.
`default_nettype none

package pcfk_pkg;

  // Design constants.
  localparam int CORDIC_STEPS = 16;
  localparam int POS_WIDTH    = 24;
  localparam int TABLE_LEN    = 24;
  localparam int ITER_N       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int IDX_W        = $clog2(TABLE_LEN);

  // Field widths.
  localparam int LEN_W = 16;
  localparam int ANG_W = 16;
  localparam int OUT_W = 24;

  // Internal widths: wrapped angle sum, CORDIC angle, vector, rounded delta.
  localparam int SUMA_W = ANG_W + 2;
  localparam int ATAN_W = 23;
  localparam int Z_W    = 25;
  localparam int XY_W   = 36;
  localparam int X0_W   = 32;
  localparam int GAIN_W = 30;
  localparam int PROD_W = LEN_W + GAIN_W;
  localparam int D_W    = XY_W - 16 + 1;
  localparam int PSUM_W = ((POS_WIDTH > D_W) ? POS_WIDTH : D_W) + 1;

  // Angle constants in 1/128 degree.
  localparam logic signed [SUMA_W-1:0] HALF_TURN    = SUMA_W'(23040);
  localparam logic signed [SUMA_W-1:0] FULL_TURN    = SUMA_W'(46080);
  localparam logic signed [SUMA_W-1:0] QUARTER_TURN = SUMA_W'(11520);

  // CORDIC gain 0.607252935 in Q30.
  localparam logic [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(652032875);

  // Saturation bounds of the running position, at the sum width.
  localparam logic signed [PSUM_W-1:0] POS_MAX =
      {{(PSUM_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [PSUM_W-1:0] POS_MIN = ~POS_MAX;

  // Input item.
  typedef struct packed {
    logic                    chain_start;
    logic [LEN_W-1:0]        link_length;
    logic signed [ANG_W-1:0] link_angle;
  } pcfk_in_t;

  // Result item.
  typedef struct packed {
    logic signed [OUT_W-1:0] end_x;
    logic signed [OUT_W-1:0] end_y;
    logic signed [ANG_W-1:0] abs_angle;
    logic                    clipped;
  } pcfk_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             prep;
    logic             step;
    logic [IDX_W-1:0] idx;
    logic             finish;
  } pcfk_cmd_t;

  // atan(2^-i) in degrees, Q16.
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/planar_chain_forward_kinematics.sv
// Top level of the planar chain forward kinematics block: controller plus datapath.
// Depends on pcfk_pkg, pcfk_ctrl and pcfk_dp.
//
//   Channel   Ports                          Moves per transfer
//   input     in_valid, in_ready, in_data    one link: start flag, length, angle
//   result    out_valid, out_ready, out_data end point, absolute angle, clip flag
//
// Each link passes through one load step, one preparation step with the gain multiply,
// ITER_N CORDIC steps (16 by default) in the shared rotation unit and one update step.
// The next input transfer is accepted only after the update step of the previous link.
// The result register is loaded in the update step.
// A result waiting in the output register does not block the next input transfer;
// only the update cycle waits for the register to drain.
// Reset is synchronous, active low, and returns the chain to the origin at angle zero.
`default_nettype none

module planar_chain_forward_kinematics (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  pcfk_pkg::pcfk_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output pcfk_pkg::pcfk_out_t  out_data
);
  import pcfk_pkg::*;

  pcfk_cmd_t cmd;

  // Sequencer.
  pcfk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  pcfk_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### sv/pcfk_ctrl.sv
// Controller of the forward kinematics block: sequences load, preparation,
// CORDIC iterations and the final update. Depends on pcfk_pkg.
`default_nettype none

module pcfk_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  output pcfk_pkg::pcfk_cmd_t  cmd
);
  import pcfk_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_ITER = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ITER_N - 1);

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // The result register may be loaded when empty or when its transfer completes.
  assign out_free = !out_valid_r || out_ready;

  // Next state, iteration count and commands.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    cmd.idx    = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.step = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag.
  always_comb begin
    priority if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### sv/pcfk_dp.sv
// Datapath of the forward kinematics block: angle wrap, gain multiply,
// shared CORDIC rotation unit and saturating position update. Depends on pcfk_pkg.
`default_nettype none

module pcfk_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  pcfk_pkg::pcfk_cmd_t  cmd,
  input  pcfk_pkg::pcfk_in_t   in_data,
  output pcfk_pkg::pcfk_out_t  out_data
);
  import pcfk_pkg::*;

  // Saturate a position sum; the top bit of the result is the hit flag.
  function automatic logic [POS_WIDTH:0] sat_pos(input logic signed [PSUM_W-1:0] v);
    logic [POS_WIDTH:0] r;
    priority if (v > POS_MAX) begin
      r = {1'b1, POS_MAX[POS_WIDTH-1:0]};
    end else if (v < POS_MIN) begin
      r = {1'b1, POS_MIN[POS_WIDTH-1:0]};
    end else begin
      r = {1'b0, v[POS_WIDTH-1:0]};
    end
    return r;
  endfunction

  logic [LEN_W-1:0]            len_r;
  logic signed [ANG_W-1:0]     rel_r;
  logic signed [ANG_W-1:0]     total_r, total_nxt;
  logic signed [POS_WIDTH-1:0] pos_x_r, pos_y_r;
  logic signed [POS_WIDTH-1:0] pos_x_nxt, pos_y_nxt;
  logic                        flip_r, flip_nxt;
  logic signed [XY_W-1:0]      x_r, y_r, x_nxt, y_nxt;
  logic signed [Z_W-1:0]       z_r, z_nxt;
  pcfk_out_t                   out_r;

  logic signed [SUMA_W-1:0]    asum, awrap, ared;
  logic [PROD_W-1:0]           prod, prod_rnd;
  logic signed [XY_W-1:0]      xs, ys;
  logic signed [Z_W-1:0]       atan_z;
  logic signed [XY_W-1:0]      xr_rnd, yr_rnd;
  logic signed [D_W-1:0]       dx, dy;
  logic signed [PSUM_W-1:0]    sum_x, sum_y;
  logic [POS_WIDTH:0]          sat_x, sat_y;

  // Preparation: wrap the absolute angle, fold to +-90 degrees, scale the length.
  always_comb begin
    asum = {{(SUMA_W-ANG_W){total_r[ANG_W-1]}}, total_r}
         + {{(SUMA_W-ANG_W){rel_r[ANG_W-1]}}, rel_r};
    priority if (asum >= HALF_TURN) begin
      awrap = asum - FULL_TURN;
    end else if (asum < -HALF_TURN) begin
      awrap = asum + FULL_TURN;
    end else begin
      awrap = asum;
    end
    total_nxt = awrap[ANG_W-1:0];
    priority if (awrap > QUARTER_TURN) begin
      ared     = awrap - HALF_TURN;
      flip_nxt = 1'b1;
    end else if (awrap < -QUARTER_TURN) begin
      ared     = awrap + HALF_TURN;
      flip_nxt = 1'b1;
    end else begin
      ared     = awrap;
      flip_nxt = 1'b0;
    end
    prod     = PROD_W'(len_r) * PROD_W'(GAIN_Q30);
    prod_rnd = prod + PROD_W'(8192);
  end

  // Start vector in preparation, then one CORDIC micro-rotation per step, index from the controller.
  always_comb begin
    xs     = x_r >>> cmd.idx;
    ys     = y_r >>> cmd.idx;
    atan_z = {{(Z_W-ATAN_W){1'b0}}, atan_q16(cmd.idx)};
    x_nxt  = x_r;
    y_nxt  = y_r;
    z_nxt  = z_r;
    priority if (cmd.prep) begin
      x_nxt = {{(XY_W-X0_W){1'b0}}, prod_rnd[PROD_W-1:14]};
      y_nxt = '0;
      z_nxt = {ared[Z_W-10:0], 9'b0};
    end else if (cmd.step) begin
      if (!z_r[Z_W-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_z;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_z;
      end
    end else begin
      x_nxt = x_r;
    end
  end

  // Final update: round, undo the fold, add and saturate.
  always_comb begin
    xr_rnd = x_r + XY_W'(32768);
    yr_rnd = y_r + XY_W'(32768);
    dx     = {xr_rnd[XY_W-1], xr_rnd[XY_W-1:16]};
    dy     = {yr_rnd[XY_W-1], yr_rnd[XY_W-1:16]};
    if (flip_r) begin
      dx = -dx;
      dy = -dy;
    end
    sum_x = {{(PSUM_W-POS_WIDTH){pos_x_r[POS_WIDTH-1]}}, pos_x_r}
          + {{(PSUM_W-D_W){dx[D_W-1]}}, dx};
    sum_y = {{(PSUM_W-POS_WIDTH){pos_y_r[POS_WIDTH-1]}}, pos_y_r}
          + {{(PSUM_W-D_W){dy[D_W-1]}}, dy};
    sat_x = sat_pos(sum_x);
    sat_y = sat_pos(sum_y);
    pos_x_nxt = sat_x[POS_WIDTH-1:0];
    pos_y_nxt = sat_y[POS_WIDTH-1:0];
  end

  // Chain state: position and absolute angle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      total_r <= '0;
    end else begin
      if (cmd.load && in_data.chain_start) begin
        pos_x_r <= '0;
        pos_y_r <= '0;
        total_r <= '0;
      end
      if (cmd.prep) begin
        total_r <= total_nxt;
      end
      if (cmd.finish) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
      end
    end
  end

  // Working registers of the current link.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r <= in_data.link_length;
      rel_r <= in_data.link_angle;
    end
    if (cmd.prep) begin
      flip_r <= flip_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.end_x     <= OUT_W'(pos_x_nxt);
      out_r.end_y     <= OUT_W'(pos_y_nxt);
      out_r.abs_angle <= total_r;
      out_r.clipped   <= sat_x[POS_WIDTH] | sat_y[POS_WIDTH];
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

### sv/pcfk_checker.sv
// Port checker for the planar chain forward kinematics block, with its bind.
// Depends on pcfk_pkg and the assertion macros header.
`default_nettype none

`include "planar_chain_forward_kinematics_defines.svh"

module pcfk_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input pcfk_pkg::pcfk_in_t  in_data,
  input wire                 out_valid,
  input wire                 out_ready,
  input pcfk_pkg::pcfk_out_t out_data
);
  import pcfk_pkg::*;

  logic in_xfer;
  logic in_start;

  assign in_xfer  = in_valid && in_ready;
  assign in_start = in_data.chain_start;

  // A stalled result holds its value.
  `PCFK_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // One link is processed at a time.
  `PCFK_ASSERT_NXT(a_one_item, clk, rst_n, in_xfer, !in_ready, "input taken during processing")

  // A result never appears right after an input transfer.
  `PCFK_ASSERT_NXT(a_no_early, clk, rst_n, in_xfer || (in_xfer && in_start), !$rose(out_valid), "result too early")

  // The absolute angle stays wrapped to plus or minus 180 degrees.
  `PCFK_ASSERT_IMP(a_angle_rng, clk, rst_n, out_valid, (out_data.abs_angle >= -16'sd23040) && (out_data.abs_angle <= 16'sd23039), "angle out of range")

endmodule

bind planar_chain_forward_kinematics pcfk_checker u_pcfk_checker (.*);

`default_nettype wire

### dv/tb_planar_chain_forward_kinematics.sv
// Self-checking testbench for the planar chain forward kinematics block.
// It drives links, predicts each end point with its own CORDIC, and compares results in order.
// Depends on pcfk_pkg and planar_chain_forward_kinematics.

module tb_planar_chain_forward_kinematics;

  import pcfk_pkg::pcfk_in_t;
  import pcfk_pkg::pcfk_out_t;

  localparam int HALF_PERIOD = 10;
  localparam int TURN_90     = 11520;
  localparam int TURN_180    = 23040;
  localparam int TURN_360    = 46080;
  localparam int DIAG_45     = 5760;
  localparam longint CORDIC_GAIN = 64'sd652032875;
  localparam int ROT_STEPS   = (pcfk_pkg::CORDIC_STEPS < 24) ? pcfk_pkg::CORDIC_STEPS : 24;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 60;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  pcfk_in_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  pcfk_out_t out_data;

  // atan(2^-i) in degrees, scaled by 2^16.
  longint arctan_q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Running state of the predicted chain.
  longint chain_x       = 0;
  longint chain_y       = 0;
  int     chain_heading = 0;

  pcfk_out_t expected_poses[$];

  int   err_count       = 0;
  int   links_sent      = 0;
  int   chains_started  = 0;
  int   results_checked = 0;
  int   clipped_seen    = 0;
  int   wraps_seen      = 0;
  int   rx_hold         = 0;
  logic rx_calm         = 1'b0;
  bit   tx_calm         = 1'b0;

  planar_chain_forward_kinematics dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Advance the predicted chain by one link and return the expected end point.
  function automatic pcfk_out_t advance_chain(input pcfk_in_t link);
    longint    len, x, y, z, xs, ys, dx, dy, lim;
    int        sum;
    bit        flip;
    bit        hit;
    pcfk_out_t pose;
    flip = 1'b0;
    hit  = 1'b0;
    if (link.chain_start) begin
      chain_x       = 0;
      chain_y       = 0;
      chain_heading = 0;
    end
    // Accumulate the heading and wrap it into [-180, +180).
    sum = chain_heading + int'($signed(link.link_angle));
    if (sum >= TURN_180 || sum < -TURN_180) wraps_seen++;
    while (sum >= TURN_180) sum -= TURN_360;
    while (sum < -TURN_180) sum += TURN_360;
    chain_heading = sum;
    // Fold wide headings into the right half plane; the delta is negated later.
    if (sum > TURN_90) begin
      sum  -= TURN_180;
      flip  = 1'b1;
    end else if (sum < -TURN_90) begin
      sum  += TURN_180;
      flip  = 1'b1;
    end
    // CORDIC rotation of a gain-compensated vector.
    len = longint'(link.link_length);
    x   = (len * CORDIC_GAIN + 64'sd8192) >>> 14;
    y   = 0;
    z   = longint'(sum) * 512;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= arctan_q16[i];
      end else begin
        x += ys;
        y -= xs;
        z += arctan_q16[i];
      end
    end
    dx = (x + 64'sd32768) >>> 16;
    dy = (y + 64'sd32768) >>> 16;
    if (flip) begin
      dx = -dx;
      dy = -dy;
    end
    // Accumulate and saturate the end point.
    lim     = (longint'(1) << (pcfk_pkg::POS_WIDTH - 1)) - 1;
    chain_x = chain_x + dx;
    chain_y = chain_y + dy;
    if (chain_x > lim) begin
      chain_x = lim;
      hit     = 1'b1;
    end else if (chain_x < -lim - 1) begin
      chain_x = -lim - 1;
      hit     = 1'b1;
    end
    if (chain_y > lim) begin
      chain_y = lim;
      hit     = 1'b1;
    end else if (chain_y < -lim - 1) begin
      chain_y = -lim - 1;
      hit     = 1'b1;
    end
    pose.end_x     = chain_x[pcfk_pkg::OUT_W-1:0];
    pose.end_y     = chain_y[pcfk_pkg::OUT_W-1:0];
    pose.abs_angle = chain_heading[15:0];
    pose.clipped   = hit;
    return pose;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pcfk_in_t make_link(input bit start, input int len, input int ang);
    pcfk_in_t link;
    link.chain_start = start;
    link.link_length = len[15:0];
    link.link_angle  = ang[15:0];
    return link;
  endfunction

  // Random link: lengths stress both ends, angles mostly in range with some raw words.
  function automatic pcfk_in_t random_link(input bit start);
    int r_len, r_ang, len, ang;
    r_len = $urandom_range(0, 99);
    r_ang = $urandom_range(0, 99);
    if (r_len < 10) len = $urandom_range(0, 3);
    else if (r_len < 20) len = 65535 - $urandom_range(0, 3);
    else len = $urandom_range(0, 65535);
    if (r_ang < 70) ang = $urandom_range(0, TURN_360 - 1) - TURN_180;
    else if (r_ang < 85) ang = $urandom_range(0, 512) - 256;
    else if (r_ang < 92) ang = TURN_90 + $urandom_range(0, 2) - 1;
    else ang = $urandom_range(0, 65535);
    return make_link(start, len, ang);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (after %0d checked results)",
             what, got, want, results_checked);
    err_count++;
  endtask

  // Send one link, holding valid until the transfer, then record its expected pose.
  task automatic send_link(input pcfk_in_t link);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= link;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_poses.insert(expected_poses.size(), advance_chain(link));
    links_sent++;
    if (link.chain_start) chains_started++;
  endtask

  // Hold off the sender until every pending result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_poses.size() != 0) @(posedge clk);
  endtask

  // Extremes of both fields, the quarter-turn fold, the wrap at 180 and raw angle words.
  task automatic test_directed();
    send_link(make_link(1'b1, 0, 0));
    send_link(make_link(1'b1, 65535, 0));
    send_link(make_link(1'b0, 65535, TURN_90));
    send_link(make_link(1'b0, 65535, 1));
    send_link(make_link(1'b0, 1, 0));
    send_link(make_link(1'b1, 32768, TURN_180 - 1));
    send_link(make_link(1'b0, 4660, 1));
    send_link(make_link(1'b1, 65535, -TURN_180));
    send_link(make_link(1'b1, 300, -TURN_90));
    send_link(make_link(1'b0, 300, -1));
    send_link(make_link(1'b0, 300, TURN_180));
    send_link(make_link(1'b1, 21845, 32767));
    send_link(make_link(1'b0, 43690, -32768));
    send_link(make_link(1'b0, 255, 32767));
    send_link(make_link(1'b0, 65280, -1));
    send_link(make_link(1'b1, 65535, 1));
    send_link(make_link(1'b0, 65535, -2));
    send_link(make_link(1'b0, 0, DIAG_45));
    send_link(make_link(1'b0, 1, -DIAG_45));
    send_link(make_link(1'b0, 2, TURN_90 + 1));
    send_link(make_link(1'b0, 128, -TURN_90 - 1));
    wait_drained();
  endtask

  // A long straight chain of near-maximum links that runs into the position limit.
  task automatic run_straight_chain(input int heading, input int links);
    send_link(make_link(1'b1, 65535, heading));
    for (int i = 1; i < links; i++) begin
      send_link(make_link(1'b0, $urandom_range(60000, 65535), $urandom_range(0, 20) - 10));
    end
  endtask

  task automatic test_saturation();
    run_straight_chain(0, 135);
    run_straight_chain(-TURN_180, 135);
    run_straight_chain(DIAG_45, 190);
    run_straight_chain(-TURN_180 + DIAG_45, 190);
    wait_drained();
  endtask

  // Well-formed chains with random content, mixed with links whose start flag is random.
  task automatic test_random_chains(input int n_links);
    int  sent;
    int  chain_len;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_links) begin
      if ($urandom_range(0, 99) < 85) begin
        chain_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        for (int i = 0; i < chain_len; i++) begin
          send_link(random_link(i == 0));
        end
        sent += chain_len;
      end else begin
        send_link(random_link($urandom_range(0, 1)));
        sent++;
      end
      if (!paused && sent > n_links / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    wait_drained();
  endtask

  // Both sides at full rate: the sender adds no idle gaps and the result side is always ready.
  task automatic test_back_to_back(input int n_links);
    tx_calm  = 1'b1;
    rx_calm <= 1'b1;
    for (int i = 0; i < n_links; i++) begin
      send_link(random_link(i % 16 == 0));
    end
    wait_drained();
    tx_calm  = 1'b0;
    rx_calm <= 1'b0;
  endtask

  // Result side: random stalls of random length, or always ready in calm phases.
  always @(posedge clk) begin
    if (!rst_n || rx_calm) begin
      out_ready <= rst_n;
      rx_hold    = 0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      rx_hold = pick_gap();
      if (rx_hold == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_hold--;
      end
    end
  end

  // Compare each result transfer with the oldest pending pose.
  always @(posedge clk) begin : check_poses
    pcfk_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_poses.size() == 0) begin
        report_mismatch("result with nothing pending, end_x", longint'(out_data.end_x), 0);
      end else begin
        want = expected_poses.pop_front();
        if (out_data.end_x !== want.end_x)
          report_mismatch("end_x", longint'(out_data.end_x), longint'(want.end_x));
        if (out_data.end_y !== want.end_y)
          report_mismatch("end_y", longint'(out_data.end_y), longint'(want.end_y));
        if (out_data.abs_angle !== want.abs_angle)
          report_mismatch("abs_angle", longint'(out_data.abs_angle), longint'(want.abs_angle));
        if (out_data.clipped !== want.clipped)
          report_mismatch("clipped", longint'(out_data.clipped), longint'(want.clipped));
        results_checked++;
        if (want.clipped) clipped_seen++;
      end
    end
  end

  // End the run if no transfer happens on either channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence: reset, the tests in turn, drain, verdict.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_saturation();
    test_random_chains(500);
    test_back_to_back(80);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_poses.size() != 0)
      report_mismatch("results never produced, count", expected_poses.size(), 0);

    $display("Covered %0d links in %0d chains: %0d results checked, %0d clipped, %0d angle wraps.",
             links_sent, chains_started, results_checked, clipped_seen, wraps_seen);
    $display("Mismatches reported: %0d", err_count);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
